/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DLMB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define DLMB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/dlmb_pkg.sv */
// types, sizes and codes of the dense layer
`default_nettype none

package dlmb_pkg;

	localparam int IN_COUNT   = 784;
	localparam int OUT_COUNT  = 10;
	localparam int DATA_WIDTH = 16;
	localparam int ACC_WIDTH  = 48;

	localparam int ROW_W = (IN_COUNT > 1) ? $clog2(IN_COUNT) : 1;
	localparam int COL_W = (OUT_COUNT > 1) ? $clog2(OUT_COUNT) : 1;

	localparam int OP_W      = 2;
	localparam int IN_IDX_W  = 10;
	localparam int OUT_IDX_W = 4;
	localparam int RES_W     = 48;

	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	typedef enum logic [1:0] {
		ITEM_NONE   = 2'd0,
		ITEM_WT     = 2'd1,
		ITEM_BIAS   = 2'd2,
		ITEM_SAMPLE = 2'd3
	} kind_t;

	// item travelling down the chain of cells
	typedef struct packed {
		kind_t                        kind;
		logic [ROW_W-1:0]             row;
		logic [COL_W-1:0]             col;
		logic signed [DATA_WIDTH-1:0] value;
		logic                         final_smp;
	} item_t;

	// finished sum held by one cell
	typedef struct packed {
		logic                 valid;
		logic [ACC_WIDTH-1:0] value;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/dlmb_cell.sv */
// one output neuron: weight column, bias, multiply-accumulate and result slot
`default_nettype none

module dlmb_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [dlmb_pkg::COL_W-1:0]     cell_id,
	input  wire dlmb_pkg::item_t                item_in,
	output dlmb_pkg::item_t                     item_out,
	input  wire logic                           take,
	output dlmb_pkg::res_t                      res
);

	localparam int DW = dlmb_pkg::DATA_WIDTH;
	localparam int AW = dlmb_pkg::ACC_WIDTH;

	logic signed [DW-1:0]   wmem [dlmb_pkg::IN_COUNT];
	logic signed [DW-1:0]   bias_q;

	dlmb_pkg::kind_t        kind_q;
	dlmb_pkg::item_t        pay_q;

	logic                   mac_s1;
	logic                   mac_s2;
	logic signed [DW-1:0]   rd_s1;
	logic signed [DW-1:0]   sample_s1;
	logic signed [DW-1:0]   bias_s1;
	logic                   final_s1;
	logic signed [2*DW-1:0] prod_s2;
	logic signed [DW-1:0]   bias_s2;
	logic                   final_s2;

	logic [AW-1:0]          acc_q;
	logic [AW-1:0]          res_value_q;
	logic                   res_vld_q;

	logic                   wt_hit;
	logic                   bias_hit;
	logic signed [AW-1:0]   prod_ext;
	logic signed [AW-1:0]   bias_ext;
	logic [AW-1:0]          sum;

	assign wt_hit   = (item_in.kind == dlmb_pkg::ITEM_WT) && (item_in.col == cell_id);
	assign bias_hit = (item_in.kind == dlmb_pkg::ITEM_BIAS) && (item_in.col == cell_id);

	// weight column of this neuron
	always_ff @(posedge clk) begin
		if (wt_hit) begin
			wmem[item_in.row] <= item_in.value;
		end
		rd_s1 <= wmem[item_in.row];
	end

	always_ff @(posedge clk) begin
		if (bias_hit) begin
			bias_q <= item_in.value;
		end
		pay_q     <= item_in;
		sample_s1 <= item_in.value;
		bias_s1   <= bias_q;
		final_s1  <= item_in.final_smp;
		prod_s2   <= sample_s1 * rd_s1;
		bias_s2   <= bias_s1;
		final_s2  <= final_s1;
		if (mac_s2 && final_s2) begin
			res_value_q <= sum;
		end
	end

	always_comb begin
		prod_ext = AW'(prod_s2);
		bias_ext = '0;
		if (final_s2) begin
			bias_ext = AW'(bias_s2);
		end
		sum = acc_q + prod_ext + bias_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= dlmb_pkg::ITEM_NONE;
			mac_s1    <= 1'b0;
			mac_s2    <= 1'b0;
			acc_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			kind_q <= item_in.kind;
			mac_s1 <= (item_in.kind == dlmb_pkg::ITEM_SAMPLE);
			mac_s2 <= mac_s1;
			if (mac_s2) begin
				// last sample of the vector empties the accumulator
				acc_q <= final_s2 ? '0 : sum;
			end
			if (mac_s2 && final_s2) begin
				res_vld_q <= 1'b1;
			end else if (take) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		item_out      = pay_q;
		item_out.kind = kind_q;
	end

	assign res.valid = res_vld_q;
	assign res.value = res_value_q;

endmodule

`default_nettype wire

/* rtl/core/dense_layer_matvec_bias.sv */
// channel  direction  payload
// in       sink       op, in_index, out_index, weight_value, bias_value, sample
// out      source     result, result_index, last
//
// while the input is open, one item is taken per cycle: a weight or bias write, or a
// sample that all neurons multiply and accumulate as it moves one cell further down
// the chain each cycle. the last sample of a vector closes the input until all
// OUT_COUNT results are transferred.
// reset clears the accumulators, the sample counter and all valid flags; weight and
// bias memories keep no reset value. out_ready low only holds the readout.
`default_nettype none
`include "assert_macros.svh"

module dense_layer_matvec_bias (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [dlmb_pkg::OP_W-1:0]              op,
	input  wire logic [dlmb_pkg::IN_IDX_W-1:0]          in_index,
	input  wire logic [dlmb_pkg::OUT_IDX_W-1:0]         out_index,
	input  wire logic signed [dlmb_pkg::DATA_WIDTH-1:0] weight_value,
	input  wire logic signed [dlmb_pkg::DATA_WIDTH-1:0] bias_value,
	input  wire logic signed [dlmb_pkg::DATA_WIDTH-1:0] sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [dlmb_pkg::RES_W-1:0]                  result,
	output logic [dlmb_pkg::OUT_IDX_W-1:0]              result_index,
	output logic                                        last
);

	localparam int OC = dlmb_pkg::OUT_COUNT;

	dlmb_pkg::item_t                  chain [OC+1];
	dlmb_pkg::res_t                   res [OC];
	logic [OC-1:0]                    res_vld;
	logic [OC-1:0]                    take;

	dlmb_pkg::kind_t                  head_kind_q;
	dlmb_pkg::item_t                  head_pay_q;
	dlmb_pkg::kind_t                  dec_kind;
	logic signed [dlmb_pkg::DATA_WIDTH-1:0] dec_value;

	logic [dlmb_pkg::ROW_W-1:0]       count_q;
	logic [dlmb_pkg::COL_W-1:0]       ptr_q;
	logic                             busy_q;

	logic                             in_xfer;
	logic                             out_xfer;
	logic                             row_ok;
	logic                             col_ok;
	logic                             is_final;
	logic                             ptr_last;

	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	assign row_ok   = 32'(in_index) < dlmb_pkg::IN_COUNT;
	assign col_ok   = 32'(out_index) < dlmb_pkg::OUT_COUNT;
	assign is_final = (count_q == dlmb_pkg::ROW_W'(dlmb_pkg::IN_COUNT - 1));

	always_comb begin
		dec_kind  = dlmb_pkg::ITEM_NONE;
		dec_value = sample;
		unique case (op)
			dlmb_pkg::OP_WEIGHT: begin
				dec_value = weight_value;
				if (row_ok && col_ok) begin
					dec_kind = dlmb_pkg::ITEM_WT;
				end
			end
			dlmb_pkg::OP_BIAS: begin
				dec_value = bias_value;
				if (col_ok) begin
					dec_kind = dlmb_pkg::ITEM_BIAS;
				end
			end
			dlmb_pkg::OP_SAMPLE: begin
				dec_kind = dlmb_pkg::ITEM_SAMPLE;
			end
			default: begin
				dec_kind = dlmb_pkg::ITEM_NONE;
			end
		endcase
	end

	// samples take their row from the counter, writes from the item
	always_ff @(posedge clk) begin
		head_pay_q.kind      <= dlmb_pkg::ITEM_NONE;
		head_pay_q.row       <= (op == dlmb_pkg::OP_SAMPLE) ? count_q
		                        : dlmb_pkg::ROW_W'(in_index);
		head_pay_q.col       <= dlmb_pkg::COL_W'(out_index);
		head_pay_q.value     <= dec_value;
		head_pay_q.final_smp <= is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_kind_q <= dlmb_pkg::ITEM_NONE;
			count_q     <= '0;
			ptr_q       <= '0;
			busy_q      <= 1'b0;
		end else begin
			head_kind_q <= in_xfer ? dec_kind : dlmb_pkg::ITEM_NONE;
			if (in_xfer && (dec_kind == dlmb_pkg::ITEM_SAMPLE)) begin
				if (is_final) begin
					count_q <= '0;
					busy_q  <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_xfer) begin
				if (ptr_last) begin
					ptr_q  <= '0;
					busy_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		chain[0]      = head_pay_q;
		chain[0].kind = head_kind_q;
	end

	for (genvar j = 0; j < OC; j++) begin : g_cell
		assign take[j]    = out_xfer && (ptr_q == dlmb_pkg::COL_W'(j));
		assign res_vld[j] = res[j].valid;

		dlmb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (dlmb_pkg::COL_W'(j)),
			.item_in  (chain[j]),
			.item_out (chain[j+1]),
			.take     (take[j]),
			.res      (res[j])
		);
	end

	// results leave in neuron order
	assign ptr_last     = (ptr_q == dlmb_pkg::COL_W'(OC - 1));
	assign out_valid    = res[ptr_q].valid;
	assign result       = dlmb_pkg::RES_W'(res[ptr_q].value);
	assign result_index = dlmb_pkg::OUT_IDX_W'(ptr_q);
	assign last         = ptr_last;

	`DLMB_ASSERT(a_out_only_busy, out_valid |-> busy_q, "result offered outside a readout")
	`DLMB_ASSERT(a_idle_no_result, in_ready |-> (res_vld == '0), "stale result while input open")
	`DLMB_ASSERT(a_last_clears, (out_xfer && last) |=> !out_valid, "result left after last transfer")
	`DLMB_NEVER(a_final_exit_idle, (chain[OC].kind == dlmb_pkg::ITEM_SAMPLE) && chain[OC].final_smp && !busy_q, "final sample in chain without readout")

endmodule

`default_nettype wire
